// ----- src/smo_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and helper functions of the sliding-mode rotor observer.
package smo_pkg;

    localparam int DATA_W    = 32;
    localparam int ANGLE_W   = 16;
    localparam int MUL_A_W   = 36;
    localparam int MUL_B_W   = 33;
    localparam int PROD_W    = MUL_A_W + MUL_B_W;
    localparam int CORDIC_W  = 36;

    localparam int SETTLE_SAMPLES   = 500;
    localparam int HOLD_SAMPLES     = 2000;
    localparam int MISMATCH_SAMPLES = 100;
    localparam int CORDIC_STEPS     = 16;

    localparam logic [63:0] EMF_MIN_SQ      = 64'd429496;
    localparam logic [18:0] TWO_PI_Q16      = 19'd411775;
    localparam logic [31:0] INV_TWO_PI_Q32  = 32'd683565276;
    localparam logic [31:0] ACCUM_LIMIT     = 32'd655360000;
    localparam logic [31:0] ERR_LOW         = 32'd32768;
    localparam logic [31:0] ERR_HIGH        = 32'd98304;
    localparam logic [9:0]  SPEED_COEF      = 10'd655;
    localparam logic [16:0] ENC_TOL         = 17'd3129;
    localparam logic [17:0] ONE_Q16         = 18'd65536;

    localparam logic [30:0] RESISTANCE_RST  = 31'd3277;
    localparam logic [30:0] POL_RST         = 31'd218453;
    localparam logic [31:0] PERIOD_RST      = 32'd214748;
    localparam logic [30:0] SLIDE_GAIN_RST  = 31'd655360;
    localparam logic [15:0] EMF_COEF_RST    = 16'd15667;
    localparam logic [30:0] PROP_GAIN_RST   = 31'd13107200;
    localparam logic [30:0] INT_GAIN_RST    = 31'd3276800;

    typedef enum logic [2:0] {
        CFG_RESISTANCE = 3'd0,
        CFG_POL        = 3'd1,
        CFG_PERIOD     = 3'd2,
        CFG_SLIDE_GAIN = 3'd3,
        CFG_EMF_COEF   = 3'd4,
        CFG_PROP_GAIN  = 3'd5,
        CFG_INT_GAIN   = 3'd6,
        CFG_ENABLE     = 3'd7
    } t_cfg_reg;

    typedef enum logic [1:0] {
        CONV_INIT       = 2'd0,
        CONV_CONVERGING = 2'd1,
        CONV_LOCKED     = 2'd2
    } t_conv_state;

    typedef enum logic [4:0] {
        SEQ_IDLE, SEQ_ERR, SEQ_RA, SEQ_RB, SEQ_PA, SEQ_PB, SEQ_EA, SEQ_EB,
        SEQ_SA, SEQ_SB, SEQ_COR, SEQ_DL, SEQ_KP, SEQ_KI, SEQ_T1, SEQ_T2,
        SEQ_T3, SEQ_OM, SEQ_S1, SEQ_S2, SEQ_S3, SEQ_C2, SEQ_C3, SEQ_SP,
        SEQ_OUT
    } t_seq;

    typedef struct packed {
        logic busy;
        logic done;
    } t_cordic_stat;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [PROD_W-1:0] x);
        logic signed [PROD_W-1:0] hi;
        logic signed [PROD_W-1:0] lo;
        hi = PROD_W'(signed'(32'sh7FFF_FFFF));
        lo = PROD_W'(signed'(32'sh8000_0000));
        if (x > hi) begin
            return 32'sh7FFF_FFFF;
        end else if (x < lo) begin
            return 32'sh8000_0000;
        end
        return x[DATA_W-1:0];
    endfunction

    function automatic logic [31:0] atan_entry(input logic [4:0] i);
        logic [31:0] v;
        unique case (i)
            5'd0:  v = 32'h2000_0000;
            5'd1:  v = 32'h12E4_051E;
            5'd2:  v = 32'h09FB_385B;
            5'd3:  v = 32'h0511_11D4;
            5'd4:  v = 32'h028B_0D43;
            5'd5:  v = 32'h0145_D7E1;
            5'd6:  v = 32'h00A2_F61E;
            5'd7:  v = 32'h0051_7C55;
            5'd8:  v = 32'h0028_BE53;
            5'd9:  v = 32'h0014_5F2F;
            5'd10: v = 32'h000A_2F98;
            5'd11: v = 32'h0005_17CC;
            5'd12: v = 32'h0002_8BE6;
            5'd13: v = 32'h0001_45F3;
            5'd14: v = 32'h0000_A2FA;
            5'd15: v = 32'h0000_517D;
            5'd16: v = 32'h0000_28BE;
            5'd17: v = 32'h0000_145F;
            5'd18: v = 32'h0000_0A30;
            5'd19: v = 32'h0000_0518;
            5'd20: v = 32'h0000_028C;
            5'd21: v = 32'h0000_0146;
            5'd22: v = 32'h0000_00A3;
            5'd23: v = 32'h0000_0051;
            default: v = 32'h0000_0000;
        endcase
        return v;
    endfunction

endpackage

// ----- src/smo_in_if.sv -----
`timescale 1ns / 1ps
// Input channel: voltages, measured currents and encoder angle of one control period.
interface smo_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [smo_pkg::DATA_W-1:0]   volt_alpha;
    logic signed [smo_pkg::DATA_W-1:0]   volt_beta;
    logic signed [smo_pkg::DATA_W-1:0]   amp_alpha;
    logic signed [smo_pkg::DATA_W-1:0]   amp_beta;
    logic        [smo_pkg::ANGLE_W-1:0]  encoder_angle;
    logic                                check_encoder;

    modport source (
        output valid, volt_alpha, volt_beta, amp_alpha, amp_beta, encoder_angle,
               check_encoder,
        input  ready
    );
    modport sink (
        input  valid, volt_alpha, volt_beta, amp_alpha, amp_beta, encoder_angle,
               check_encoder,
        output ready
    );
endinterface

// ----- src/smo_out_if.sv -----
`timescale 1ns / 1ps
// Output channel: rotor angle, speed, back-EMF and observer status.
interface smo_out_if;
    logic                                valid;
    logic                                ready;
    logic        [smo_pkg::ANGLE_W-1:0]  rotor_angle;
    logic signed [smo_pkg::DATA_W-1:0]   rotor_speed;
    logic signed [smo_pkg::DATA_W-1:0]   emf_alpha;
    logic signed [smo_pkg::DATA_W-1:0]   emf_beta;
    logic        [1:0]                   observer_status;
    logic        [smo_pkg::DATA_W-1:0]   error_magnitude;
    logic                                encoder_fault;

    modport source (
        output valid, rotor_angle, rotor_speed, emf_alpha, emf_beta, observer_status,
               error_magnitude, encoder_fault,
        input  ready
    );
    modport sink (
        input  valid, rotor_angle, rotor_speed, emf_alpha, emf_beta, observer_status,
               error_magnitude, encoder_fault,
        output ready
    );
endinterface

// ----- src/sliding_mode_rotor_observer.sv -----
`timescale 1ns / 1ps
// Top level: sequencer and datapath of the sliding-mode rotor observer with PLL.
//
// Channel   Dir  Handshake         Carries
// i_in      in   valid / ready     volt, amp (alpha/beta), encoder angle, check flag
// o_out     out  valid / ready     rotor angle, speed, EMF, status, error, fault
// i_cfg_*   in   write enable      register index, register data
//
// One word at a time: i_in.ready is high only while idle. An enabled word steps
// through the sequencer from SEQ_ERR to SEQ_SP, waiting in SEQ_COR for the CORDIC
// when the EMF is large enough to form a new angle; a disabled word goes straight
// to SEQ_OUT; the shared multiplier and the CORDIC iterations set this order. Reset
// is synchronous and needs no clearing pass. A result is held on o_out until taken.
module sliding_mode_rotor_observer (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    smo_in_if.sink                            i_in,
    smo_out_if.source                         o_out,
    input  logic                              i_cfg_we,
    input  logic [2:0]                        i_cfg_index,
    input  logic [smo_pkg::DATA_W-1:0]        i_cfg_data
);
    localparam int PW = smo_pkg::PROD_W;

    // configuration
    logic [30:0] r_res;
    logic [30:0] r_pol;
    logic [31:0] r_ts;
    logic [30:0] r_k;
    logic [15:0] r_coef;
    logic [30:0] r_kp;
    logic [30:0] r_ki;
    logic        r_enable;

    // estimator state
    logic signed [31:0]    r_iha;
    logic signed [31:0]    r_ihb;
    logic signed [31:0]    r_ea;
    logic signed [31:0]    r_eb;
    logic        [15:0]    r_est_angle;
    logic        [15:0]    r_tracked;
    logic signed [31:0]    r_accum;
    logic signed [31:0]    r_speed;
    smo_pkg::t_conv_state  r_conv;
    logic        [8:0]     r_settle;
    logic        [10:0]    r_hold;
    logic        [15:0]    r_mis;

    // per-word working registers
    logic signed [31:0] r_va;
    logic signed [31:0] r_vb;
    logic signed [31:0] r_ia;
    logic signed [31:0] r_ib;
    logic        [15:0] r_enc;
    logic               r_chk;
    logic signed [17:0] r_za;
    logic signed [17:0] r_zb;
    logic signed [31:0] r_inner_a;
    logic signed [31:0] r_inner_b;
    logic        [62:0] r_sq;
    logic signed [18:0] r_drad;
    logic signed [34:0] r_pp;
    logic signed [35:0] r_p;
    logic signed [51:0] r_hi;
    logic signed [31:0] r_omega;
    logic        [31:0] r_err;
    logic               r_fault;

    smo_pkg::t_seq r_seq;
    smo_pkg::t_seq n_seq;

    logic signed [smo_pkg::MUL_A_W-1:0] w_mul_a;
    logic signed [smo_pkg::MUL_B_W-1:0] w_mul_b;
    logic signed [PW-1:0]               w_prod;
    logic signed [PW-1:0]               w_ps16;
    logic                               w_cor_start;
    smo_pkg::t_cordic_stat              w_cstat;
    logic        [15:0]                 w_cor_angle;

    logic                w_in_acc;
    logic signed [32:0]  w_da;
    logic signed [32:0]  w_db;
    logic        [32:0]  w_abs_a;
    logic        [32:0]  w_abs_b;
    logic        [33:0]  w_esum;
    logic        [63:0]  w_sq;
    logic                w_emf_big;
    logic signed [15:0]  w_delta;
    logic signed [PW-1:0] w_kz_a;
    logic signed [PW-1:0] w_kz_b;
    logic signed [PW-1:0] w_q;
    logic signed [PW-1:0] w_acc;
    logic signed [PW-1:0] w_s2;
    logic signed [PW-1:0] w_cnt;
    logic signed [15:0]  w_enc_d;
    logic        [16:0]  w_enc_abs;
    logic        [8:0]   w_settle_inc;
    logic        [10:0]  w_hold_inc;
    logic        [15:0]  w_mis_inc;
    logic signed [PW-1:0] w_lim;

    smo_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_p   (w_prod)
    );

    smo_cordic u_cordic (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_cor_start),
        .i_emf_alpha (r_ea),
        .i_emf_beta  (r_eb),
        .o_stat      (w_cstat),
        .o_angle     (w_cor_angle)
    );

    assign w_in_acc  = i_in.valid && i_in.ready;
    assign w_ps16    = w_prod >>> 16;
    assign w_da      = 33'(r_ia) - 33'(r_iha);
    assign w_db      = 33'(r_ib) - 33'(r_ihb);
    assign w_abs_a   = (w_da < 0) ? 33'(-w_da) : 33'(w_da);
    assign w_abs_b   = (w_db < 0) ? 33'(-w_db) : 33'(w_db);
    assign w_esum    = 34'(w_abs_a) + 34'(w_abs_b);
    assign w_sq      = 64'(r_sq) + 64'(w_prod[62:0]);
    assign w_emf_big = w_sq > smo_pkg::EMF_MIN_SQ;
    assign w_delta   = signed'(r_est_angle - r_tracked);
    assign w_kz_a    = (r_za > 0) ? PW'(signed'({1'b0, r_k}))
                     : (r_za < 0) ? -PW'(signed'({1'b0, r_k})) : '0;
    assign w_kz_b    = (r_zb > 0) ? PW'(signed'({1'b0, r_k}))
                     : (r_zb < 0) ? -PW'(signed'({1'b0, r_k})) : '0;
    assign w_q       = (PW'(r_hi) + w_ps16) >>> 16;
    assign w_acc     = PW'(r_accum) + w_q;
    assign w_lim     = PW'(signed'({1'b0, smo_pkg::ACCUM_LIMIT}));
    assign w_s2      = ((PW'(r_hi) + w_ps16) >>> 16) <<< 1;
    assign w_cnt     = (((PW'(r_hi) + w_ps16) >>> 16) + PW'(1)) >>> 1;
    assign w_enc_d   = signed'(r_enc - r_est_angle);
    assign w_enc_abs = (w_enc_d < 0) ? -17'(w_enc_d) : 17'(w_enc_d);
    assign w_settle_inc = r_settle + 9'd1;
    assign w_hold_inc   = r_hold + 11'd1;
    assign w_mis_inc    = (r_mis != 16'hFFFF) ? r_mis + 16'd1 : r_mis;

    // next state
    always_comb begin
        n_seq = r_seq;
        unique case (r_seq)
            smo_pkg::SEQ_IDLE: begin
                if (w_in_acc) begin
                    n_seq = r_enable ? smo_pkg::SEQ_ERR : smo_pkg::SEQ_OUT;
                end
            end
            smo_pkg::SEQ_ERR: n_seq = smo_pkg::SEQ_RA;
            smo_pkg::SEQ_RA:  n_seq = smo_pkg::SEQ_RB;
            smo_pkg::SEQ_RB:  n_seq = smo_pkg::SEQ_PA;
            smo_pkg::SEQ_PA:  n_seq = smo_pkg::SEQ_PB;
            smo_pkg::SEQ_PB:  n_seq = smo_pkg::SEQ_EA;
            smo_pkg::SEQ_EA:  n_seq = smo_pkg::SEQ_EB;
            smo_pkg::SEQ_EB:  n_seq = smo_pkg::SEQ_SA;
            smo_pkg::SEQ_SA:  n_seq = smo_pkg::SEQ_SB;
            smo_pkg::SEQ_SB:  n_seq = w_emf_big ? smo_pkg::SEQ_COR : smo_pkg::SEQ_DL;
            smo_pkg::SEQ_COR: begin
                if (w_cstat.done) begin
                    n_seq = smo_pkg::SEQ_DL;
                end
            end
            smo_pkg::SEQ_DL:  n_seq = smo_pkg::SEQ_KP;
            smo_pkg::SEQ_KP:  n_seq = smo_pkg::SEQ_KI;
            smo_pkg::SEQ_KI:  n_seq = smo_pkg::SEQ_T1;
            smo_pkg::SEQ_T1:  n_seq = smo_pkg::SEQ_T2;
            smo_pkg::SEQ_T2:  n_seq = smo_pkg::SEQ_T3;
            smo_pkg::SEQ_T3:  n_seq = smo_pkg::SEQ_OM;
            smo_pkg::SEQ_OM:  n_seq = smo_pkg::SEQ_S1;
            smo_pkg::SEQ_S1:  n_seq = smo_pkg::SEQ_S2;
            smo_pkg::SEQ_S2:  n_seq = smo_pkg::SEQ_S3;
            smo_pkg::SEQ_S3:  n_seq = smo_pkg::SEQ_C2;
            smo_pkg::SEQ_C2:  n_seq = smo_pkg::SEQ_C3;
            smo_pkg::SEQ_C3:  n_seq = smo_pkg::SEQ_SP;
            smo_pkg::SEQ_SP:  n_seq = smo_pkg::SEQ_OUT;
            smo_pkg::SEQ_OUT: begin
                if (o_out.ready) begin
                    n_seq = smo_pkg::SEQ_IDLE;
                end
            end
            default: n_seq = smo_pkg::SEQ_IDLE;
        endcase
    end

    // multiplier operands and CORDIC start strobe
    always_comb begin
        w_mul_a     = '0;
        w_mul_b     = '0;
        w_cor_start = 1'b0;
        unique case (r_seq)
            smo_pkg::SEQ_ERR: begin
                w_mul_a = 36'(r_iha);
                w_mul_b = signed'({2'b00, r_res});
            end
            smo_pkg::SEQ_RA: begin
                w_mul_a = 36'(r_ihb);
                w_mul_b = signed'({2'b00, r_res});
            end
            smo_pkg::SEQ_RB: begin
                w_mul_a = 36'(r_inner_a);
                w_mul_b = signed'({2'b00, r_pol});
            end
            smo_pkg::SEQ_PA: begin
                w_mul_a = 36'(r_inner_b);
                w_mul_b = signed'({2'b00, r_pol});
            end
            smo_pkg::SEQ_PB: begin
                w_mul_a = 36'(r_za) - 36'(r_ea);
                w_mul_b = signed'({17'b0, r_coef});
            end
            smo_pkg::SEQ_EA: begin
                w_mul_a = 36'(r_zb) - 36'(r_eb);
                w_mul_b = signed'({17'b0, r_coef});
            end
            smo_pkg::SEQ_EB: begin
                w_mul_a = 36'(r_ea);
                w_mul_b = 33'(r_ea);
            end
            smo_pkg::SEQ_SA: begin
                w_mul_a = 36'(r_eb);
                w_mul_b = 33'(r_eb);
            end
            smo_pkg::SEQ_SB: w_cor_start = w_emf_big;
            smo_pkg::SEQ_DL: begin
                w_mul_a = 36'(w_delta);
                w_mul_b = signed'({14'b0, smo_pkg::TWO_PI_Q16});
            end
            smo_pkg::SEQ_KP: begin
                w_mul_a = 36'(w_ps16);
                w_mul_b = signed'({2'b00, r_kp});
            end
            smo_pkg::SEQ_KI: begin
                w_mul_a = 36'(r_drad);
                w_mul_b = signed'({2'b00, r_ki});
            end
            smo_pkg::SEQ_T1: begin
                w_mul_a = 36'(w_ps16);
                w_mul_b = signed'({17'b0, r_ts[31:16]});
            end
            smo_pkg::SEQ_T2: begin
                w_mul_a = r_p;
                w_mul_b = signed'({17'b0, r_ts[15:0]});
            end
            smo_pkg::SEQ_S1: begin
                w_mul_a = 36'(r_omega);
                w_mul_b = signed'({17'b0, r_ts[31:16]});
            end
            smo_pkg::SEQ_S2: begin
                w_mul_a = 36'(r_omega);
                w_mul_b = signed'({17'b0, r_ts[15:0]});
            end
            smo_pkg::SEQ_S3: begin
                w_mul_a = 36'(w_s2);
                w_mul_b = signed'({17'b0, smo_pkg::INV_TWO_PI_Q32[31:16]});
            end
            smo_pkg::SEQ_C2: begin
                w_mul_a = r_p;
                w_mul_b = signed'({17'b0, smo_pkg::INV_TWO_PI_Q32[15:0]});
            end
            smo_pkg::SEQ_C3: begin
                w_mul_a = 36'(r_omega) - 36'(r_speed);
                w_mul_b = signed'({23'b0, smo_pkg::SPEED_COEF});
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign i_in.ready            = (r_seq == smo_pkg::SEQ_IDLE);
    assign o_out.valid           = (r_seq == smo_pkg::SEQ_OUT);
    assign o_out.rotor_angle     = r_est_angle;
    assign o_out.rotor_speed     = r_speed;
    assign o_out.emf_alpha       = r_ea;
    assign o_out.emf_beta        = r_eb;
    assign o_out.observer_status = r_conv;
    assign o_out.error_magnitude = r_err;
    assign o_out.encoder_fault   = r_fault;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq <= smo_pkg::SEQ_IDLE;
        end else begin
            r_seq <= n_seq;
        end
    end

    // configuration and estimator state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res       <= smo_pkg::RESISTANCE_RST;
            r_pol       <= smo_pkg::POL_RST;
            r_ts        <= smo_pkg::PERIOD_RST;
            r_k         <= smo_pkg::SLIDE_GAIN_RST;
            r_coef      <= smo_pkg::EMF_COEF_RST;
            r_kp        <= smo_pkg::PROP_GAIN_RST;
            r_ki        <= smo_pkg::INT_GAIN_RST;
            r_enable    <= 1'b1;
            r_iha       <= '0;
            r_ihb       <= '0;
            r_ea        <= '0;
            r_eb        <= '0;
            r_est_angle <= '0;
            r_tracked   <= '0;
            r_accum     <= '0;
            r_speed     <= '0;
            r_conv      <= smo_pkg::CONV_INIT;
            r_settle    <= '0;
            r_hold      <= '0;
            r_mis       <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (smo_pkg::t_cfg_reg'(i_cfg_index))
                    smo_pkg::CFG_RESISTANCE: r_res    <= i_cfg_data[30:0];
                    smo_pkg::CFG_POL:        r_pol    <= i_cfg_data[30:0];
                    smo_pkg::CFG_PERIOD:     r_ts     <= i_cfg_data;
                    smo_pkg::CFG_SLIDE_GAIN: r_k      <= i_cfg_data[30:0];
                    smo_pkg::CFG_EMF_COEF:   r_coef   <= i_cfg_data[15:0];
                    smo_pkg::CFG_PROP_GAIN:  r_kp     <= i_cfg_data[30:0];
                    smo_pkg::CFG_INT_GAIN:   r_ki     <= i_cfg_data[30:0];
                    smo_pkg::CFG_ENABLE:     r_enable <= i_cfg_data[0];
                    default: ;
                endcase
            end
            unique case (r_seq)
                smo_pkg::SEQ_PA: r_iha <= smo_pkg::sat32(PW'(r_iha) + w_ps16 - w_kz_a);
                smo_pkg::SEQ_PB: r_ihb <= smo_pkg::sat32(PW'(r_ihb) + w_ps16 - w_kz_b);
                smo_pkg::SEQ_EA: r_ea  <= smo_pkg::sat32(PW'(r_ea) + w_ps16);
                smo_pkg::SEQ_EB: r_eb  <= smo_pkg::sat32(PW'(r_eb) + w_ps16);
                smo_pkg::SEQ_COR: begin
                    if (w_cstat.done) begin
                        r_est_angle <= w_cor_angle;
                    end
                end
                smo_pkg::SEQ_T3: begin
                    if (w_acc > w_lim) begin
                        r_accum <= 32'(w_lim);
                    end else if (w_acc < -w_lim) begin
                        r_accum <= 32'(-w_lim);
                    end else begin
                        r_accum <= w_acc[31:0];
                    end
                end
                smo_pkg::SEQ_C3: r_tracked <= r_tracked + w_cnt[15:0];
                smo_pkg::SEQ_SP: begin
                    r_speed <= smo_pkg::sat32(PW'(r_speed) + ((w_prod + PW'(32768)) >>> 16));
                    unique case (r_conv)
                        smo_pkg::CONV_INIT: begin
                            if (r_err < smo_pkg::ERR_LOW) begin
                                r_settle <= w_settle_inc;
                                if (32'(w_settle_inc) >= 32'(smo_pkg::SETTLE_SAMPLES)) begin
                                    r_conv <= smo_pkg::CONV_CONVERGING;
                                    r_hold <= '0;
                                end
                            end else begin
                                r_settle <= '0;
                            end
                        end
                        smo_pkg::CONV_CONVERGING: begin
                            if (r_err < smo_pkg::ERR_LOW) begin
                                r_hold <= w_hold_inc;
                                if (32'(w_hold_inc) >= 32'(smo_pkg::HOLD_SAMPLES)) begin
                                    r_conv <= smo_pkg::CONV_LOCKED;
                                end
                            end else begin
                                r_hold <= '0;
                            end
                        end
                        smo_pkg::CONV_LOCKED: begin
                            if (r_err > smo_pkg::ERR_HIGH) begin
                                r_conv <= smo_pkg::CONV_CONVERGING;
                                r_hold <= '0;
                            end
                        end
                        default: ;
                    endcase
                    if (r_chk) begin
                        if (w_enc_abs > smo_pkg::ENC_TOL) begin
                            r_mis <= w_mis_inc;
                        end else if (r_mis != '0) begin
                            r_mis <= r_mis - 16'd1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // working registers of the word in flight
    always_ff @(posedge i_clk) begin
        unique case (r_seq)
            smo_pkg::SEQ_IDLE: begin
                if (w_in_acc) begin
                    r_va    <= i_in.volt_alpha;
                    r_vb    <= i_in.volt_beta;
                    r_ia    <= i_in.amp_alpha;
                    r_ib    <= i_in.amp_beta;
                    r_enc   <= i_in.encoder_angle;
                    r_chk   <= i_in.check_encoder;
                    r_err   <= '0;
                    r_fault <= 1'b0;
                end
            end
            smo_pkg::SEQ_ERR: begin
                // z = sign(estimate - measured)
                r_za  <= (w_da < 0) ? signed'(smo_pkg::ONE_Q16)
                       : (w_da > 0) ? -signed'(smo_pkg::ONE_Q16) : '0;
                r_zb  <= (w_db < 0) ? signed'(smo_pkg::ONE_Q16)
                       : (w_db > 0) ? -signed'(smo_pkg::ONE_Q16) : '0;
                r_err <= (w_esum[33:32] != 2'b00) ? 32'hFFFF_FFFF : w_esum[31:0];
            end
            smo_pkg::SEQ_RA: r_inner_a <= smo_pkg::sat32(PW'(r_va) - w_ps16 - PW'(r_ea));
            smo_pkg::SEQ_RB: r_inner_b <= smo_pkg::sat32(PW'(r_vb) - w_ps16 - PW'(r_eb));
            smo_pkg::SEQ_SA: r_sq      <= w_prod[62:0];
            smo_pkg::SEQ_KP: r_drad    <= w_ps16[18:0];
            smo_pkg::SEQ_KI: r_pp      <= w_ps16[34:0];
            smo_pkg::SEQ_T1: r_p       <= w_ps16[35:0];
            smo_pkg::SEQ_T2: r_hi      <= w_prod[51:0];
            smo_pkg::SEQ_OM: r_omega   <= smo_pkg::sat32(PW'(r_pp) + PW'(r_accum));
            smo_pkg::SEQ_S2: r_hi      <= w_prod[51:0];
            smo_pkg::SEQ_S3: r_p       <= w_s2[35:0];
            smo_pkg::SEQ_C2: r_hi      <= w_prod[51:0];
            smo_pkg::SEQ_SP: begin
                if (r_chk && w_enc_abs > smo_pkg::ENC_TOL) begin
                    r_fault <= 32'(w_mis_inc) >= 32'(smo_pkg::MISMATCH_SAMPLES);
                end
            end
            default: ;
        endcase
    end

    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in.ready && o_out.valid))
        else $error("input taken while a result is pending");

    a_bypass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && !r_enable) |=> o_out.valid)
        else $error("disabled word did not go straight to the output");

    a_cordic_owned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cstat.busy |-> (r_seq == smo_pkg::SEQ_COR))
        else $error("CORDIC running outside its sequencer step");

    a_fault_needs_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.encoder_fault) |-> (r_chk && r_enable))
        else $error("encoder fault without an enabled check");
endmodule

// ----- src/smo_mul.sv -----
`timescale 1ns / 1ps
// Shared signed multiplier with registered product.
module smo_mul (
    input  logic                                i_clk,
    input  logic signed [smo_pkg::MUL_A_W-1:0]  i_a,
    input  logic signed [smo_pkg::MUL_B_W-1:0]  i_b,
    output logic signed [smo_pkg::PROD_W-1:0]   o_p
);
    logic signed [smo_pkg::PROD_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= smo_pkg::PROD_W'(i_a) * smo_pkg::PROD_W'(i_b);
    end

    assign o_p = r_p;
endmodule

// ----- src/smo_cordic.sv -----
`timescale 1ns / 1ps
// Iterative vectoring CORDIC giving atan2(-emf_alpha, emf_beta) in 16-bit turns.
module smo_cordic (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic signed [smo_pkg::DATA_W-1:0]  i_emf_alpha,
    input  logic signed [smo_pkg::DATA_W-1:0]  i_emf_beta,
    output smo_pkg::t_cordic_stat              o_stat,
    output logic        [smo_pkg::ANGLE_W-1:0] o_angle
);
    logic signed [smo_pkg::CORDIC_W-1:0] r_x;
    logic signed [smo_pkg::CORDIC_W-1:0] r_y;
    logic        [31:0]                  r_ang;
    logic        [4:0]                   r_step;
    logic                                r_busy;
    logic                                r_done;

    logic signed [smo_pkg::CORDIC_W-1:0] w_x0;
    logic signed [smo_pkg::CORDIC_W-1:0] w_y0;
    logic signed [smo_pkg::CORDIC_W-1:0] w_xs;
    logic signed [smo_pkg::CORDIC_W-1:0] w_ys;
    logic        [31:0]                  w_tab;
    logic        [31:0]                  w_round;

    assign w_x0    = smo_pkg::CORDIC_W'(i_emf_beta);
    assign w_y0    = -smo_pkg::CORDIC_W'(i_emf_alpha);
    assign w_xs    = r_x >>> r_step;
    assign w_ys    = r_y >>> r_step;
    assign w_tab   = smo_pkg::atan_entry(r_step);
    assign w_round = r_ang + 32'h0000_8000;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 5'd1;
                if (r_step == 5'(smo_pkg::CORDIC_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // fold the left half plane over before rotating
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            if (w_x0 < 0) begin
                r_x   <= -w_x0;
                r_y   <= -w_y0;
                r_ang <= 32'h8000_0000;
            end else begin
                r_x   <= w_x0;
                r_y   <= w_y0;
                r_ang <= 32'h0000_0000;
            end
        end else if (r_busy) begin
            if (r_y > 0) begin
                r_x   <= r_x + w_ys;
                r_y   <= r_y - w_xs;
                r_ang <= r_ang + w_tab;
            end else begin
                r_x   <= r_x - w_ys;
                r_y   <= r_y + w_xs;
                r_ang <= r_ang - w_tab;
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_angle     = w_round[31:16];
endmodule
